@@ rtl/wtbc_pkg.sv @@
// Package: sizes, payload types and control structs of the trend buffer compactor.
`timescale 1ns / 1ps

package wtbc_pkg;

    localparam int SLOT_COUNT   = 64;
    localparam int IDX_W        = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W        = $clog2(SLOT_COUNT + 1);
    localparam int ADDR_W       = IDX_W + 1;
    localparam int STORE_DEPTH  = 1 << ADDR_W;
    localparam int DATA_W       = 32;
    localparam int SLOT_INDEX_W = 6;

    typedef logic signed [DATA_W-1:0] coord_t;
    typedef logic [IDX_W-1:0]         slot_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } seq_state_t;

    typedef struct packed {
        logic      wr_en;
        logic      wr_bank;
        slot_idx_t wr_idx;
        coord_t    wr_x;
        coord_t    wr_y;
        logic      rd_en;
        logic      rd_bank;
        slot_idx_t rd_idx;
        logic      clr_en;
        logic      clr_bank;
    } store_ctl_t;

    typedef struct packed {
        coord_t rd_x;
        coord_t rd_y;
        logic   rd_valid;
    } store_rsp_t;

endpackage

@@ rtl/wtbc_if.sv @@
// Interfaces: update channel and slot result channel.
`timescale 1ns / 1ps

interface wtbc_upd_if;
    import wtbc_pkg::*;

    logic   valid;
    logic   ready;
    coord_t new_x;
    coord_t new_y;
    logic   new_present;
    coord_t window_low;
    coord_t window_high;

    modport source (
        output valid, new_x, new_y, new_present, window_low, window_high,
        input  ready
    );

    modport sink (
        input  valid, new_x, new_y, new_present, window_low, window_high,
        output ready
    );
endinterface

interface wtbc_slot_if;
    import wtbc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [SLOT_INDEX_W-1:0] slot_index;
    coord_t                  slot_x;
    coord_t                  slot_y;
    logic                    slot_valid;
    logic                    last_slot;

    modport source (
        output valid, slot_index, slot_x, slot_y, slot_valid, last_slot,
        input  ready
    );

    modport sink (
        input  valid, slot_index, slot_x, slot_y, slot_valid, last_slot,
        output ready
    );
endinterface

@@ rtl/wtbc_win_cmp.sv @@
// Shared window compare unit: inclusive signed range check on one x value.
`timescale 1ns / 1ps

module wtbc_win_cmp
    import wtbc_pkg::*;
(
    input  coord_t x,
    input  coord_t lo,
    input  coord_t hi,
    output logic   hit
);

    assign hit = (lo <= x) && (x <= hi);

endmodule

@@ rtl/wtbc_store.sv @@
// Two-bank slot store: x/y memory with registered read and per-slot valid marks.
`timescale 1ns / 1ps

module wtbc_store
    import wtbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  store_ctl_t ctl,
    output store_rsp_t rsp
);

    logic [2*DATA_W-1:0]    mem [0:STORE_DEPTH-1];
    logic [2*DATA_W-1:0]    rd_data_reg;
    logic                   rd_mark_reg;
    logic [STORE_DEPTH-1:0] marks_reg;
    logic [STORE_DEPTH-1:0] marks_next;

    always_comb
    begin
        marks_next = marks_reg;
        if (ctl.clr_en)
        begin
            for (int i = 0; i < (1 << IDX_W); i++)
            begin
                marks_next[{ctl.clr_bank, IDX_W'(i)}] = 1'b0;
            end
        end
        if (ctl.wr_en)
        begin
            marks_next[{ctl.wr_bank, ctl.wr_idx}] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marks_reg <= '0;
        end
        else
        begin
            marks_reg <= marks_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[{ctl.wr_bank, ctl.wr_idx}] <= {ctl.wr_x, ctl.wr_y};
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[{ctl.rd_bank, ctl.rd_idx}];
            rd_mark_reg <= marks_reg[{ctl.rd_bank, ctl.rd_idx}];
        end
    end

    assign rsp.rd_x     = rd_data_reg[2*DATA_W-1:DATA_W];
    assign rsp.rd_y     = rd_data_reg[DATA_W-1:0];
    assign rsp.rd_valid = rd_mark_reg;

endmodule

@@ rtl/windowed_trend_buffer_compactor.sv @@
// Top level: sequencer that compacts the trace into the spare bank and emits all slots.
//
//   channel | dir | transaction
//   --------+-----+---------------------------------------------------------
//   upd     | in  | new point, present flag, inclusive x window
//   slot    | out | one slot per transaction, index 0 first, last_slot on top
//
// An update runs two passes from accept to the last slot loaded: one pass of
// SLOT_COUNT reads over the old bank to compact, then one pass over the new
// bank to emit, both through the single memory read port.
// upd.ready is high only between updates; the last slot may still be waiting.
// A stalled slot channel holds the emit pass; the compact pass never stalls.
// Reset empties every slot at once; no clearing pass.
`timescale 1ns / 1ps

module windowed_trend_buffer_compactor
    import wtbc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    wtbc_upd_if.sink      upd,
    wtbc_slot_if.source   slot
);

    seq_state_t state_reg, state_next;
    logic       cur_bank_reg, cur_bank_next;
    logic [CNT_W-1:0] iss_left_reg, iss_left_next;
    logic [CNT_W-1:0] fill_cnt_reg, fill_cnt_next;
    logic       rd_pend_reg, rd_pend_next;
    slot_idx_t  rd_idx_reg, rd_idx_next;
    coord_t     lo_reg, lo_next;
    coord_t     hi_reg, hi_next;

    logic                    ov_reg, ov_next;
    logic [SLOT_INDEX_W-1:0] oidx_reg;
    coord_t                  ox_reg;
    coord_t                  oy_reg;
    logic                    oval_reg;
    logic                    olast_reg;

    store_ctl_t st_ctl;
    store_rsp_t st_rsp;

    coord_t cmp_x, cmp_lo, cmp_hi;
    logic   cmp_hit;

    logic             upd_accept;
    logic             out_free;
    logic             emit_load;
    logic [CNT_W-1:0] iss_m1;
    logic [CNT_W-1:0] fill_m1;
    logic [CNT_W-1:0] emit_pos;
    slot_idx_t        scan_idx;
    slot_idx_t        emit_idx;
    slot_idx_t        fill_idx;

    assign upd.ready  = (state_reg == ST_IDLE);
    assign upd_accept = upd.valid && upd.ready;
    assign out_free   = !ov_reg || slot.ready;
    assign emit_load  = (state_reg == ST_EMIT) && rd_pend_reg && out_free;

    assign iss_m1   = iss_left_reg - CNT_W'(1);
    assign fill_m1  = fill_cnt_reg - CNT_W'(1);
    assign emit_pos = CNT_W'(SLOT_COUNT) - iss_left_reg;
    assign scan_idx = iss_m1[IDX_W-1:0];
    assign fill_idx = fill_m1[IDX_W-1:0];
    assign emit_idx = emit_pos[IDX_W-1:0];

    assign cmp_x  = (state_reg == ST_IDLE) ? upd.new_x       : st_rsp.rd_x;
    assign cmp_lo = (state_reg == ST_IDLE) ? upd.window_low  : lo_reg;
    assign cmp_hi = (state_reg == ST_IDLE) ? upd.window_high : hi_reg;

    wtbc_win_cmp u_cmp (
        .x   (cmp_x),
        .lo  (cmp_lo),
        .hi  (cmp_hi),
        .hit (cmp_hit)
    );

    wtbc_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (st_ctl),
        .rsp   (st_rsp)
    );

    always_comb
    begin
        state_next    = state_reg;
        cur_bank_next = cur_bank_reg;
        iss_left_next = iss_left_reg;
        fill_cnt_next = fill_cnt_reg;
        rd_pend_next  = rd_pend_reg;
        rd_idx_next   = rd_idx_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        st_ctl        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (upd_accept)
                begin
                    lo_next         = upd.window_low;
                    hi_next         = upd.window_high;
                    st_ctl.clr_en   = 1'b1;
                    st_ctl.clr_bank = !cur_bank_reg;
                    if (upd.new_present && cmp_hit)
                    begin
                        st_ctl.wr_en   = 1'b1;
                        st_ctl.wr_bank = !cur_bank_reg;
                        st_ctl.wr_idx  = IDX_W'(SLOT_COUNT - 1);
                        st_ctl.wr_x    = upd.new_x;
                        st_ctl.wr_y    = upd.new_y;
                        fill_cnt_next  = CNT_W'(SLOT_COUNT - 1);
                    end
                    else
                    begin
                        fill_cnt_next = CNT_W'(SLOT_COUNT);
                    end
                    iss_left_next = CNT_W'(SLOT_COUNT);
                    rd_pend_next  = 1'b0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                st_ctl.rd_en   = (iss_left_reg != '0);
                st_ctl.rd_bank = cur_bank_reg;
                st_ctl.rd_idx  = scan_idx;
                if (st_ctl.rd_en)
                begin
                    iss_left_next = iss_m1;
                end
                rd_pend_next = st_ctl.rd_en;
                if (rd_pend_reg && st_rsp.rd_valid && cmp_hit && (fill_cnt_reg != '0))
                begin
                    st_ctl.wr_en   = 1'b1;
                    st_ctl.wr_bank = !cur_bank_reg;
                    st_ctl.wr_idx  = fill_idx;
                    st_ctl.wr_x    = st_rsp.rd_x;
                    st_ctl.wr_y    = st_rsp.rd_y;
                    fill_cnt_next  = fill_m1;
                end
                if ((iss_left_reg == '0) && !rd_pend_reg)
                begin
                    cur_bank_next = !cur_bank_reg;
                    iss_left_next = CNT_W'(SLOT_COUNT);
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                st_ctl.rd_en   = (iss_left_reg != '0) && (!rd_pend_reg || out_free);
                st_ctl.rd_bank = cur_bank_reg;
                st_ctl.rd_idx  = emit_idx;
                if (st_ctl.rd_en)
                begin
                    iss_left_next = iss_m1;
                    rd_idx_next   = emit_idx;
                end
                rd_pend_next = st_ctl.rd_en || (rd_pend_reg && !out_free);
                if ((iss_left_reg == '0) && !rd_pend_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ov_next = ov_reg && !slot.ready;
        if (emit_load)
        begin
            ov_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cur_bank_reg <= 1'b0;
            iss_left_reg <= '0;
            fill_cnt_reg <= '0;
            rd_pend_reg  <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cur_bank_reg <= cur_bank_next;
            iss_left_reg <= iss_left_next;
            fill_cnt_reg <= fill_cnt_next;
            rd_pend_reg  <= rd_pend_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_idx_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        if (emit_load)
        begin
            oidx_reg  <= SLOT_INDEX_W'(rd_idx_reg);
            ox_reg    <= st_rsp.rd_valid ? st_rsp.rd_x : '0;
            oy_reg    <= st_rsp.rd_valid ? st_rsp.rd_y : '0;
            oval_reg  <= st_rsp.rd_valid;
            olast_reg <= (rd_idx_reg == IDX_W'(SLOT_COUNT - 1));
        end
    end

    assign slot.valid      = ov_reg;
    assign slot.slot_index = oidx_reg;
    assign slot.slot_x     = ox_reg;
    assign slot.slot_y     = oy_reg;
    assign slot.slot_valid = oval_reg;
    assign slot.last_slot  = olast_reg;

`ifndef NO_ASSERTIONS
    a_scan_writes_spare_bank: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) && st_ctl.wr_en |-> st_ctl.wr_bank != cur_bank_reg)
        else $error("compaction wrote into the bank being read");

    a_emit_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> !st_ctl.wr_en)
        else $error("store written during emit pass");

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_cnt_reg <= CNT_W'(SLOT_COUNT))
        else $error("fill count out of range");

    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (iss_left_reg == '0) && !rd_pend_reg)
        else $error("idle with reads outstanding");

    a_load_after_emit_read: assert property (@(posedge clk) disable iff (!rst_n)
        emit_load |-> $past(st_ctl.rd_en) || $past(rd_pend_reg))
        else $error("slot loaded without a read behind it");
`endif

endmodule
